[rtl/accel_tilt_roll_pitch_defines.svh]
// Assertion macros shared by the tilt block
`ifndef ACCEL_TILT_ROLL_PITCH_DEFINES_SVH
`define ACCEL_TILT_ROLL_PITCH_DEFINES_SVH
// implication checked on every clock edge outside reset
`define ATRP_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ATRP_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[rtl/atrp_pkg.sv]
// Package: widths, CORDIC angle table and shared types for the tilt block
`timescale 1ns / 1ps
package atrp_pkg;
  localparam int SampleWidth = 16;
  localparam int AngleFracBits = 13;
  localparam int CordicStages = 16;
  localparam int GuardBits = 8;
  localparam int RollWidth = AngleFracBits + 3;
  localparam int PitchWidth = AngleFracBits + 2;
  // CORDIC datapath: sample plus guard plus growth
  localparam int DataWidth = SampleWidth + GuardBits + 3;
  localparam int AccWidth = 34;
  // square-root operand and result widths; keep the operand width even so
  // every step takes a whole bit pair
  localparam int SqWidth = 2 * SampleWidth + 2 + 2 * GuardBits;
  localparam int RootWidth = (SqWidth + 1) / 2;
  localparam int RootSteps = RootWidth;
  localparam int RootPerStage = 4;
  localparam int RootStages = (RootSteps + RootPerStage - 1) / RootPerStage;
  localparam int StageIdxW = $clog2(CordicStages + 1);

  localparam logic signed [AccWidth-1:0] PiQ30 = 34'sd3373259426;

  function automatic logic signed [AccWidth-1:0] atan_q30(input int i);
    logic [31:0] v;
    begin
      case (i)
        0: v = 32'h3243F6A8;   1: v = 32'h1DAC6705;   2: v = 32'h0FADBAFC;
        3: v = 32'h07F56EA6;   4: v = 32'h03FEAB76;   5: v = 32'h01FFD55B;
        6: v = 32'h00FFFAAA;   7: v = 32'h007FFF55;   8: v = 32'h003FFFEA;
        9: v = 32'h001FFFFD;   10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF;  13: v = 32'h0001FFFF;  14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF;  16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
        18: v = 32'h00000FFF;  19: v = 32'h000007FF;  20: v = 32'h000003FF;
        21: v = 32'h000001FF;  22: v = 32'h000000FF;  23: v = 32'h0000007F;
        default: v = 32'h0;
      endcase
      return $signed({2'b00, v});
    end
  endfunction

  typedef struct packed {
    logic signed [DataWidth-1:0] xs;
    logic signed [DataWidth-1:0] ys;
    logic signed [AccWidth-1:0] acc;
  } cordic_t;

  // side information travelling with each sample
  typedef struct packed {
    logic signed [SampleWidth-1:0] x;
    logic        yz_zero;
    logic        zero;
  } side_t;
endpackage

[rtl/atrp_cordic_step.sv]
// One vectoring CORDIC iteration, registered, with stall support
`timescale 1ns / 1ps
module atrp_cordic_step
  import atrp_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [StageIdxW-1:0] idx,
  input  cordic_t              d_in,
  output cordic_t              q_r
);
  cordic_t q_nxt;
  logic signed [DataWidth-1:0] dx, dy;
  logic signed [AccWidth-1:0] ang;

  always_comb begin
    dx = d_in.ys >>> idx;
    dy = d_in.xs >>> idx;
    ang = atan_q30(int'(idx));
    q_nxt = d_in;
    if (d_in.ys >= 0) begin
      q_nxt.xs = d_in.xs + dx;
      q_nxt.ys = d_in.ys - dy;
      q_nxt.acc = d_in.acc + ang;
    end else begin
      q_nxt.xs = d_in.xs - dx;
      q_nxt.ys = d_in.ys + dy;
      q_nxt.acc = d_in.acc - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end
endmodule

[rtl/atrp_sqrt_stage.sv]
// Several restoring square-root steps, registered
`timescale 1ns / 1ps
module atrp_sqrt_stage
  import atrp_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [5:0]            first_step,
  input  logic [SqWidth+1:0]    rem_in,
  input  logic [SqWidth-1:0]    op_in,
  input  logic [RootWidth-1:0]  root_in,
  output logic [SqWidth+1:0]    rem_r,
  output logic [SqWidth-1:0]    op_r,
  output logic [RootWidth-1:0]  root_r
);
  logic [SqWidth+1:0] rem_nxt, trial;
  logic [SqWidth-1:0] op_nxt;
  logic [RootWidth-1:0] root_nxt;

  // classic digit-by-digit: bring in two bits, try 4*root+1
  always_comb begin
    rem_nxt = rem_in;
    op_nxt = op_in;
    root_nxt = root_in;
    trial = '0;
    for (int k = 0; k < RootPerStage; k++) begin
      if (int'(first_step) + k < RootSteps) begin
        rem_nxt = {rem_nxt[SqWidth-1:0], op_nxt[SqWidth-1 -: 2]};
        op_nxt = {op_nxt[SqWidth-3:0], 2'b00};
        trial = (SqWidth+2)'({root_nxt, 2'b01});
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          root_nxt = {root_nxt[RootWidth-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[RootWidth-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      op_r <= op_nxt;
      root_r <= root_nxt;
    end
  end
endmodule

[rtl/accel_tilt_roll_pitch.sv]
// Top level: tilt block, roll and pitch from one accelerometer sample
// Usage: feed one signed three-axis sample per transfer on in_valid/in_ready.
// Each sample gives exactly one result on out_valid/out_ready: roll_angle
// = atan2(y, z), pitch_angle = atan2(x, sqrt(y^2+z^2)), both radians with
// 13 fraction bits, and zero_vector for an all-zero sample.
// Pipeline: one input register, the square-root stages (RootStages, 7 at the
// default widths), the pitch CORDIC (16 stages) and one output register,
// after which out_valid rises. Roll runs its 16 stage CORDIC in parallel and
// is delayed to match. Throughput: one sample every cycle while not stalled.
// The length is set by the square root feeding the pitch CORDIC.
// Stall: when out_ready is low with a result held, the whole pipeline
// freezes; in_ready falls only then, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty afterwards.
`timescale 1ns / 1ps
`include "accel_tilt_roll_pitch_defines.svh"
module accel_tilt_roll_pitch
  import atrp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SampleWidth-1:0] in_accel_x,
  input  logic signed [SampleWidth-1:0] in_accel_y,
  input  logic signed [SampleWidth-1:0] in_accel_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [RollWidth-1:0]  out_roll_angle,
  output logic signed [PitchWidth-1:0] out_pitch_angle,
  output logic                         out_zero_vector
);
  localparam int Depth = 1 + RootStages + CordicStages;

  logic en;
  logic [Depth-1:0] vld_r;
  side_t side_r [Depth];

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // input stage
  logic signed [SampleWidth-1:0] y0_r, z0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Depth-2:0], in_valid};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0].x <= in_accel_x;
      side_r[0].yz_zero <= (in_accel_y == '0) && (in_accel_z == '0);
      side_r[0].zero <= (in_accel_x == '0) && (in_accel_y == '0)
                        && (in_accel_z == '0);
      y0_r <= in_accel_y;
      z0_r <= in_accel_z;
      for (int i = 1; i < Depth; i++) side_r[i] <= side_r[i-1];
    end
  end

  // square-root operand: (y^2 + z^2) << 2*GuardBits
  logic [SqWidth-1:0] sq_op;
  logic signed [2*SampleWidth-1:0] yy, zz;
  always_comb begin
    yy = y0_r * y0_r;
    zz = z0_r * z0_r;
    sq_op = {1'b0, {1'b0, $unsigned(yy)} + {1'b0, $unsigned(zz)},
             {(2*GuardBits){1'b0}}};
  end

  logic [SqWidth+1:0] rem_w [RootStages+1];
  logic [SqWidth-1:0] op_w [RootStages+1];
  logic [RootWidth-1:0] root_w [RootStages+1];
  assign rem_w[0] = '0;
  assign op_w[0] = sq_op;
  assign root_w[0] = '0;

  genvar g;
  generate
    for (g = 0; g < RootStages; g++) begin : g_sqrt
      atrp_sqrt_stage u_sq (
        .clk(clk), .en(en), .first_step(6'(g * RootPerStage)),
        .rem_in(rem_w[g]), .op_in(op_w[g]), .root_in(root_w[g]),
        .rem_r(rem_w[g+1]), .op_r(op_w[g+1]), .root_r(root_w[g+1])
      );
    end
  endgenerate

  // roll CORDIC entry, half-plane fold on negative z
  cordic_t roll_w [CordicStages+1];
  logic roll_neg0, roll_yneg0;
  always_comb begin
    roll_neg0 = z0_r < 0;
    roll_yneg0 = y0_r < 0;
    roll_w[0].acc = '0;
    if (roll_neg0) begin
      roll_w[0].xs = -(DataWidth'(z0_r) <<< GuardBits);
      roll_w[0].ys = -(DataWidth'(y0_r) <<< GuardBits);
    end else begin
      roll_w[0].xs = DataWidth'(z0_r) <<< GuardBits;
      roll_w[0].ys = DataWidth'(y0_r) <<< GuardBits;
    end
  end

  generate
    for (g = 0; g < CordicStages; g++) begin : g_roll
      atrp_cordic_step u_rc (
        .clk(clk), .en(en), .idx(StageIdxW'(g)), .d_in(roll_w[g]), .q_r(roll_w[g+1])
      );
    end
  endgenerate

  // fold flags travel alongside the roll CORDIC
  logic [1:0] fold_r [CordicStages];
  always_ff @(posedge clk) begin
    if (en) begin
      fold_r[0] <= {roll_neg0, roll_yneg0};
      for (int i = 1; i < CordicStages; i++) fold_r[i] <= fold_r[i-1];
    end
  end

  // fold correction then delay roll to match the pitch path
  localparam int RollDly = RootStages;
  logic signed [AccWidth-1:0] roll_acc;
  always_comb begin
    roll_acc = roll_w[CordicStages].acc;
    if (fold_r[CordicStages-1][1])
      roll_acc = fold_r[CordicStages-1][0] ? roll_acc - PiQ30 : roll_acc + PiQ30;
  end
  logic signed [AccWidth-1:0] roll_dly_r [RollDly];
  always_ff @(posedge clk) begin
    if (en) begin
      roll_dly_r[0] <= roll_acc;
      for (int i = 1; i < RollDly; i++) roll_dly_r[i] <= roll_dly_r[i-1];
    end
  end

  // pitch CORDIC on (root, x << guard)
  cordic_t pit_w [CordicStages+1];
  localparam int SqIdx = RootStages;
  always_comb begin
    pit_w[0].xs = DataWidth'(root_w[RootStages]);
    pit_w[0].ys = DataWidth'(side_r[SqIdx].x) <<< GuardBits;
    pit_w[0].acc = '0;
  end
  generate
    for (g = 0; g < CordicStages; g++) begin : g_pitch
      atrp_cordic_step u_pc (
        .clk(clk), .en(en), .idx(StageIdxW'(g)), .d_in(pit_w[g]), .q_r(pit_w[g+1])
      );
    end
  endgenerate

  // roll path (input register, roll CORDIC, RollDly delay) matches the pitch path depth
  localparam int Sh = 30 - AngleFracBits;
  localparam logic signed [AccWidth-1:0] Half = AccWidth'(1) <<< (Sh - 1);
  localparam logic signed [AccWidth-Sh-1:0] PiF =
    (AccWidth-Sh)'((PiQ30 + Half) >>> Sh);
  localparam logic signed [AccWidth-Sh-1:0] HpiF =
    (AccWidth-Sh)'((34'sd1686629713 + Half) >>> Sh);

  logic signed [AccWidth-1:0] rr_t, pr_t;
  logic signed [AccWidth-Sh-1:0] rr, pr, roll_f, pitch_f;
  side_t sl;
  always_comb begin
    sl = side_r[Depth-1];
    rr_t = roll_dly_r[RollDly-1] + Half;
    pr_t = pit_w[CordicStages].acc + Half;
    rr = rr_t[AccWidth-1:Sh];
    pr = pr_t[AccWidth-1:Sh];
    if (rr > PiF) roll_f = PiF;
    else if (rr < -PiF) roll_f = -PiF;
    else roll_f = rr;
    if (pr > HpiF) pitch_f = HpiF;
    else if (pr < -HpiF) pitch_f = -HpiF;
    else pitch_f = pr;
    if (sl.yz_zero) begin
      roll_f = '0;
      if (sl.x > 0) pitch_f = HpiF;
      else if (sl.x < 0) pitch_f = -HpiF;
      else pitch_f = '0;
    end
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vld_r[Depth-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_roll_angle <= roll_f[RollWidth-1:0];
      out_pitch_angle <= pitch_f[PitchWidth-1:0];
      out_zero_vector <= sl.zero;
    end
  end
  assign out_valid = out_valid_r;

  `ATRP_ASSERT_IMP(a_stall_ready, clk, rst_n, out_valid && !out_ready, !in_ready)
  `ATRP_ASSERT_NXT(a_hold_out, clk, rst_n, out_valid && !out_ready, out_valid)
  `ATRP_ASSERT_IMP(a_zero_angles, clk, rst_n, out_valid && out_zero_vector,
                   out_roll_angle == '0 && out_pitch_angle == '0)
endmodule
